// File: hw/rtl/bpsr_pkg.sv
// ----------------------------------------------------------------------------
// bpsr_pkg
// Types and constants shared by the box pair spatial relation block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package bpsr_pkg;

	// One ordered pair of boxes, center format, unsigned Q0.16
	typedef struct packed {
		logic [15:0] subject_x;
		logic [15:0] subject_y;
		logic [15:0] subject_w;
		logic [15:0] subject_h;
		logic [15:0] object_x;
		logic [15:0] object_y;
		logic [15:0] object_w;
		logic [15:0] object_h;
		logic [5:0]  subject_index;
		logic [5:0]  object_index;
	} box_pair_t;

	typedef struct packed {
		logic [2:0] relation;
		logic [5:0] subject_out;
		logic [5:0] object_out;
	} rel_word_t;

	localparam int CFG_IDX_W = 3;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [15:0]          data;
	} cfg_word_t;

	// Relation codes
	localparam logic [2:0] REL_CONTAINS = 3'd0;
	localparam logic [2:0] REL_OVERLAPS = 3'd1;
	localparam logic [2:0] REL_LEFT_OF  = 3'd2;
	localparam logic [2:0] REL_RIGHT_OF = 3'd3;
	localparam logic [2:0] REL_ON       = 3'd4;
	localparam logic [2:0] REL_UNDER    = 3'd5;
	localparam logic [2:0] REL_NEXT_TO  = 3'd6;
	localparam logic [2:0] REL_NONE     = 3'd7;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_RATIO_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_MARGIN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TOLERANCE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_X_LIMIT        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_Y_LIMIT        = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_OVERLAP_RATIO_LIMIT = 16'd6554;
	localparam logic [15:0] RST_SIDE_MARGIN         = 16'd3277;
	localparam logic [15:0] RST_COLUMN_TOLERANCE    = 16'd13107;
	localparam logic [15:0] RST_NEAR_X_LIMIT        = 16'd19661;
	localparam logic [15:0] RST_NEAR_Y_LIMIT        = 16'd6554;

	// Box edges at doubled scale
	typedef struct packed {
		logic signed [19:0] l;
		logic signed [19:0] r;
		logic signed [19:0] t;
		logic signed [19:0] b;
		logic [16:0]        cx;
		logic [16:0]        cy;
	} box_edges_t;

	// Comparison outcomes, first match order
	typedef struct packed {
		logic contains;
		logic left;
		logic right;
		logic above;
		logic below;
		logic col_ok;
		logic near_ok;
	} rel_flags_t;

endpackage

// File: hw/rtl/bpsr_stream_if.sv
// ----------------------------------------------------------------------------
// bpsr_stream_if
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface bpsr_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/box_pair_spatial_relation.sv
// ----------------------------------------------------------------------------
// box_pair_spatial_relation
// Classifies an ordered pair of boxes as contains, overlaps, left of, right of,
// on, under or next to, first match wins.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : sink channel, one box pair word per handshake.
//   result : source channel, one relation word per pair that has a relation
//            and two different indices below MAX_DETECTIONS; other pairs are
//            dropped silently.
//   cfg    : register write channel, always ready; writes take effect at once
//            and are meant for idle periods. Indexes past the list are ignored.
// Timing: six register stages (edges, compares, area products, union, IoU
//   product, output register). One pair per cycle is accepted sustained while
//   result is not stalled; the single 16x35 threshold product stage sets the
//   clock, not the rate.
// Stall: each stage takes a new word when it is empty or its successor
//   advances, so bubbles fill while result is held; pair.ready drops only when
//   every stage holds a word and result is stalled.
// Reset: arst_n clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module box_pair_spatial_relation
	import bpsr_pkg::*;
#(
	parameter int MAX_DETECTIONS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	bpsr_stream_if.sink      pair,
	bpsr_stream_if.source    result,
	bpsr_stream_if.sink      cfg
);

	// Configuration registers
	logic [15:0] overlap_ratio_limit_q;
	logic [15:0] side_margin_q;
	logic [15:0] column_tolerance_q;
	logic [15:0] near_x_limit_q;
	logic [15:0] near_y_limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_ratio_limit_q <= RST_OVERLAP_RATIO_LIMIT;
			side_margin_q         <= RST_SIDE_MARGIN;
			column_tolerance_q    <= RST_COLUMN_TOLERANCE;
			near_x_limit_q        <= RST_NEAR_X_LIMIT;
			near_y_limit_q        <= RST_NEAR_Y_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_OVERLAP_RATIO_LIMIT: overlap_ratio_limit_q <= cfg.data.data;
				CFG_SIDE_MARGIN:         side_margin_q         <= cfg.data.data;
				CFG_COLUMN_TOLERANCE:    column_tolerance_q    <= cfg.data.data;
				CFG_NEAR_X_LIMIT:        near_x_limit_q        <= cfg.data.data;
				CFG_NEAR_Y_LIMIT:        near_y_limit_q        <= cfg.data.data;
				default: ;
			endcase
		end
	end

	// Stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || result.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pair.ready = en1;

	// Stage 1: edges at doubled scale, index check
	box_edges_t  s_box_s1, o_box_s1;
	logic [15:0] s_w_s1, s_h_s1, o_w_s1, o_h_s1;
	logic [5:0]  s_idx_s1, o_idx_s1;
	logic        idx_ok_s1;

	function automatic box_edges_t make_edges(logic [15:0] x, logic [15:0] y,
		logic [15:0] w, logic [15:0] h);
		box_edges_t e;
		logic signed [19:0] cx2, cy2, ws, hs;
		cx2 = $signed({3'b000, x, 1'b0});
		cy2 = $signed({3'b000, y, 1'b0});
		ws  = $signed({4'b0000, w});
		hs  = $signed({4'b0000, h});
		e.l  = cx2 - ws;
		e.r  = cx2 + ws;
		e.t  = cy2 - hs;
		e.b  = cy2 + hs;
		e.cx = {x, 1'b0};
		e.cy = {y, 1'b0};
		return e;
	endfunction

	logic idx_ok_in;
	assign idx_ok_in = (pair.data.subject_index != pair.data.object_index)
		&& (32'(pair.data.subject_index) < 32'(MAX_DETECTIONS))
		&& (32'(pair.data.object_index) < 32'(MAX_DETECTIONS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			s_box_s1  <= make_edges(pair.data.subject_x, pair.data.subject_y,
				pair.data.subject_w, pair.data.subject_h);
			o_box_s1  <= make_edges(pair.data.object_x, pair.data.object_y,
				pair.data.object_w, pair.data.object_h);
			s_w_s1    <= pair.data.subject_w;
			s_h_s1    <= pair.data.subject_h;
			o_w_s1    <= pair.data.object_w;
			o_h_s1    <= pair.data.object_h;
			s_idx_s1  <= pair.data.subject_index;
			o_idx_s1  <= pair.data.object_index;
			idx_ok_s1 <= idx_ok_in;
		end
	end

	// Stage 2: edge compares, center distances, intersection sides
	rel_flags_t  flags_c, flags_s2;
	logic [16:0] iw_c, ih_c, iw_s2, ih_s2;
	logic [15:0] s_w_s2, s_h_s2, o_w_s2, o_h_s2;
	logic [5:0]  s_idx_s2, o_idx_s2;
	logic        idx_ok_s2;

	logic signed [19:0] gap, min_r, max_l, min_b, max_t;
	logic signed [20:0] iw_diff, ih_diff;
	logic [16:0]        dx, dy;

	always_comb begin
		gap = $signed({3'b000, side_margin_q, 1'b0});
		dx  = (s_box_s1.cx >= o_box_s1.cx) ? s_box_s1.cx - o_box_s1.cx
			: o_box_s1.cx - s_box_s1.cx;
		dy  = (s_box_s1.cy >= o_box_s1.cy) ? s_box_s1.cy - o_box_s1.cy
			: o_box_s1.cy - s_box_s1.cy;

		flags_c.contains = ($signed(s_box_s1.l) <= $signed(o_box_s1.l))
			&& ($signed(s_box_s1.r) >= $signed(o_box_s1.r))
			&& ($signed(s_box_s1.t) <= $signed(o_box_s1.t))
			&& ($signed(s_box_s1.b) >= $signed(o_box_s1.b));
		flags_c.left    = ($signed(s_box_s1.r) + gap) < $signed(o_box_s1.l);
		flags_c.right   = $signed(s_box_s1.l) > ($signed(o_box_s1.r) + gap);
		flags_c.above   = $signed(s_box_s1.b) < $signed(o_box_s1.t);
		flags_c.below   = $signed(s_box_s1.t) > $signed(o_box_s1.b);
		flags_c.col_ok  = dx < {column_tolerance_q, 1'b0};
		flags_c.near_ok = (dx < {near_x_limit_q, 1'b0}) && (dy < {near_y_limit_q, 1'b0});

		min_r = ($signed(s_box_s1.r) < $signed(o_box_s1.r)) ? s_box_s1.r : o_box_s1.r;
		max_l = ($signed(s_box_s1.l) > $signed(o_box_s1.l)) ? s_box_s1.l : o_box_s1.l;
		min_b = ($signed(s_box_s1.b) < $signed(o_box_s1.b)) ? s_box_s1.b : o_box_s1.b;
		max_t = ($signed(s_box_s1.t) > $signed(o_box_s1.t)) ? s_box_s1.t : o_box_s1.t;
		iw_diff = 21'(min_r) - 21'(max_l);
		ih_diff = 21'(min_b) - 21'(max_t);
		// clamp to zero when the boxes are apart; a side never exceeds 17 bits
		iw_c = iw_diff[20] ? 17'd0 : iw_diff[16:0];
		ih_c = ih_diff[20] ? 17'd0 : ih_diff[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			flags_s2  <= flags_c;
			iw_s2     <= iw_c;
			ih_s2     <= ih_c;
			s_w_s2    <= s_w_s1;
			s_h_s2    <= s_h_s1;
			o_w_s2    <= o_w_s1;
			o_h_s2    <= o_h_s1;
			s_idx_s2  <= s_idx_s1;
			o_idx_s2  <= o_idx_s1;
			idx_ok_s2 <= idx_ok_s1;
		end
	end

	// Stage 3: intersection and box areas
	logic [33:0] inter_s3;
	logic [31:0] s_area_s3, o_area_s3;
	rel_flags_t  flags_s3;
	logic [5:0]  s_idx_s3, o_idx_s3;
	logic        idx_ok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			inter_s3  <= iw_s2 * ih_s2;
			s_area_s3 <= s_w_s2 * s_h_s2;
			o_area_s3 <= o_w_s2 * o_h_s2;
			flags_s3  <= flags_s2;
			s_idx_s3  <= s_idx_s2;
			o_idx_s3  <= o_idx_s2;
			idx_ok_s3 <= idx_ok_s2;
		end
	end

	// Stage 4: union at doubled scale (never negative)
	logic [34:0] uni_c, uni_s4;
	logic [33:0] inter_s4;
	rel_flags_t  flags_s4;
	logic [5:0]  s_idx_s4, o_idx_s4;
	logic        idx_ok_s4;

	assign uni_c = 35'({s_area_s3, 2'b00}) + 35'({o_area_s3, 2'b00}) - 35'(inter_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			uni_s4    <= uni_c;
			inter_s4  <= inter_s3;
			flags_s4  <= flags_s3;
			s_idx_s4  <= s_idx_s3;
			o_idx_s4  <= o_idx_s3;
			idx_ok_s4 <= idx_ok_s3;
		end
	end

	// Stage 5: threshold times union
	logic [50:0] limit_prod_s5;
	logic [33:0] inter_s5;
	logic        uni_nz_s5;
	rel_flags_t  flags_s5;
	logic [5:0]  s_idx_s5, o_idx_s5;
	logic        idx_ok_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			limit_prod_s5 <= overlap_ratio_limit_q * uni_s4;
			inter_s5      <= inter_s4;
			uni_nz_s5     <= (uni_s4 != 35'd0);
			flags_s5      <= flags_s4;
			s_idx_s5      <= s_idx_s4;
			o_idx_s5      <= o_idx_s4;
			idx_ok_s5     <= idx_ok_s4;
		end
	end

	// Stage 6: first match select, output register
	logic       overlap;
	logic [2:0] rel_c;

	always_comb begin
		overlap = uni_nz_s5 && ({1'b0, inter_s5, 16'h0000} > limit_prod_s5);
		if (flags_s5.contains) begin
			rel_c = REL_CONTAINS;
		end else if (overlap) begin
			rel_c = REL_OVERLAPS;
		end else if (flags_s5.left) begin
			rel_c = REL_LEFT_OF;
		end else if (flags_s5.right) begin
			rel_c = REL_RIGHT_OF;
		end else if (flags_s5.above && flags_s5.col_ok) begin
			rel_c = REL_ON;
		end else if (flags_s5.below && flags_s5.col_ok) begin
			rel_c = REL_UNDER;
		end else if (flags_s5.near_ok) begin
			rel_c = REL_NEXT_TO;
		end else begin
			rel_c = REL_NONE;
		end
	end

	rel_word_t out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en6) begin
			// drop pairs without a relation or with bad indices
			v_s6 <= v_s5 && idx_ok_s5 && (rel_c != REL_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			out_s6.relation    <= rel_c;
			out_s6.subject_out <= s_idx_s5;
			out_s6.object_out  <= o_idx_s5;
		end
	end

	assign result.valid = v_s6;
	assign result.data  = out_s6;

	// Checks
	a_no_none_out: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.relation != REL_NONE)
		else $error("relation word with no relation presented");

	a_distinct_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.subject_out != result.data.object_out)
		else $error("relation word with equal indices presented");

	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !result.ready))
		else $error("pair.ready low with room in the pipeline");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pair.valid && pair.ready) |=> v_s1)
		else $error("accepted pair did not enter stage one");

endmodule
